>>> sv/bma_pkg.sv
// ----------------------------------------------------------------------------
// bma_pkg: shared types and constants for the block mean ASCII mapper
// Configuration indexes, crop and tile limits, queue entry, state types and
// the glyph ramp.
// ----------------------------------------------------------------------------
package bma_pkg;

    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 14;

    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_W       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_H       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCKS_ACROSS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCKS_DOWN   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_REVERSE_MAP   = 3'd5;

    localparam int TILES_ACROSS_MAX = 1024;
    localparam int TILE_IDX_W       = 10;
    localparam int SUM_W            = 21;
    localparam int DSTEP_W          = 18;
    localparam int DIV_STEPS        = 14;

    localparam logic [3:0] LEVEL_TOP = 4'd13;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [13:0]        sw;
        logic [6:0]         bw;
        logic [7:0]         bh;
        logic [10:0]        bd;
        logic [10:0]        across;
        logic [13:0]        kept;
        logic [DSTEP_W-1:0] dstep;
        logic               reverse;
    } geom_t;

    typedef struct packed {
        logic [SUM_W-1:0]      sum;
        logic [TILE_IDX_W-1:0] tile;
        logic                  row_end;
        logic                  image_end;
    } entry_t;

    typedef enum logic [2:0] {
        GEO_READY,
        GEO_LOAD,
        GEO_DIV,
        GEO_SCALE,
        GEO_KEEP
    } geo_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CHECK,
        BK_DIV,
        BK_EMIT
    } bk_state_t;

    function automatic logic [6:0] ramp_char(input logic [3:0] level, input logic rev);
        logic [3:0] idx;
        logic [6:0] code;
        idx = rev ? (LEVEL_TOP - level) : level;
        unique case (idx)
            4'd0:    code = 7'd87;   // W
            4'd1:    code = 7'd35;   // #
            4'd2:    code = 7'd64;   // @
            4'd3:    code = 7'd48;   // 0
            4'd4:    code = 7'd38;   // &
            4'd5:    code = 7'd37;   // %
            4'd6:    code = 7'd42;   // *
            4'd7:    code = 7'd122;  // z
            4'd8:    code = 7'd61;   // =
            4'd9:    code = 7'd43;   // +
            4'd10:   code = 7'd95;   // _
            4'd11:   code = 7'd44;   // ,
            4'd12:   code = 7'd46;   // .
            default: code = 7'd32;   // space
        endcase
        return code;
    endfunction

endpackage

>>> sv/bma_geom.sv
// ----------------------------------------------------------------------------
// bma_geom: configuration registers and crop geometry
// Holds the registers, clamps them, and after every write recomputes the
// kept tile count, kept width and the level step with a serial divider.
// ----------------------------------------------------------------------------
module bma_geom
    import bma_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output geom_t                  geom,
    output logic                   ready
);

    logic [13:0] sw_raw_reg, sw_raw_next;
    logic [6:0]  bw_raw_reg, bw_raw_next;
    logic [7:0]  bh_raw_reg, bh_raw_next;
    logic [10:0] ba_raw_reg, ba_raw_next;
    logic [10:0] bd_raw_reg, bd_raw_next;
    logic        rev_reg, rev_next;

    logic [13:0] sw_c;
    logic [6:0]  bw_c;
    logic [7:0]  bh_c;
    logic [10:0] ba_c;
    logic [10:0] bd_c;

    geo_state_t  state_reg, state_next;
    logic [13:0] quo_reg, quo_next;
    logic [6:0]  rem_reg, rem_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [10:0] across_reg, across_next;
    logic [13:0] area_reg, area_next;
    logic [13:0] kept_reg, kept_next;
    logic [DSTEP_W-1:0] dstep_reg, dstep_next;

    logic        do_load, do_step, do_scale, do_keep;
    logic [7:0]  trial;
    logic        ge;

    always_comb
    begin
        sw_raw_next = sw_raw_reg;
        bw_raw_next = bw_raw_reg;
        bh_raw_next = bh_raw_reg;
        ba_raw_next = ba_raw_reg;
        bd_raw_next = bd_raw_reg;
        rev_next    = rev_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH:  sw_raw_next = cfg_data;
                REG_BLOCK_W:       bw_raw_next = cfg_data[6:0];
                REG_BLOCK_H:       bh_raw_next = cfg_data[7:0];
                REG_BLOCKS_ACROSS: ba_raw_next = cfg_data[10:0];
                REG_BLOCKS_DOWN:   bd_raw_next = cfg_data[10:0];
                REG_REVERSE_MAP:   rev_next    = cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        sw_c = (sw_raw_reg == 14'd0) ? 14'd1 : ((sw_raw_reg > 14'd8192) ? 14'd8192 : sw_raw_reg);
        bw_c = (bw_raw_reg == 7'd0) ? 7'd1 : ((bw_raw_reg > 7'd64) ? 7'd64 : bw_raw_reg);
        bh_c = (bh_raw_reg == 8'd0) ? 8'd1 : ((bh_raw_reg > 8'd128) ? 8'd128 : bh_raw_reg);
        ba_c = (ba_raw_reg == 11'd0) ? 11'd1 : ((ba_raw_reg > 11'd1024) ? 11'd1024 : ba_raw_reg);
        bd_c = (bd_raw_reg == 11'd0) ? 11'd1 : ((bd_raw_reg > 11'd1024) ? 11'd1024 : bd_raw_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        if (cfg_we)
        begin
            state_next = GEO_LOAD;
        end
        else
        begin
            unique case (state_reg)
                GEO_READY: state_next = GEO_READY;
                GEO_LOAD:  state_next = GEO_DIV;
                GEO_DIV:   state_next = (cnt_reg == 4'(DIV_STEPS - 1)) ? GEO_SCALE : GEO_DIV;
                GEO_SCALE: state_next = GEO_KEEP;
                GEO_KEEP:  state_next = GEO_READY;
                default:   state_next = GEO_READY;
            endcase
        end
    end

    always_comb
    begin
        do_load  = (state_reg == GEO_LOAD);
        do_step  = (state_reg == GEO_DIV);
        do_scale = (state_reg == GEO_SCALE);
        do_keep  = (state_reg == GEO_KEEP);
        ready    = (state_reg == GEO_READY) && !cfg_we;
    end

    always_comb
    begin
        trial       = {rem_reg, quo_reg[13]};
        ge          = trial >= {1'b0, bw_c};
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        across_next = across_reg;
        area_next   = area_reg;
        kept_next   = kept_reg;
        dstep_next  = dstep_reg;
        if (do_load)
        begin
            quo_next = sw_c;
            rem_next = 7'd0;
            cnt_next = 4'd0;
        end
        if (do_step)
        begin
            rem_next = ge ? 7'(trial - {1'b0, bw_c}) : trial[6:0];
            quo_next = {quo_reg[12:0], ge};
            cnt_next = cnt_reg + 4'd1;
        end
        if (do_scale)
        begin
            across_next = (quo_reg > {3'd0, ba_c}) ? ba_c : quo_reg[10:0];
            area_next   = 14'(bw_c * bh_c);
        end
        if (do_keep)
        begin
            kept_next  = 14'(across_reg * bw_c);
            dstep_next = DSTEP_W'(area_reg * 5'd19);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_raw_reg <= 14'd640;
            bw_raw_reg <= 7'd2;
            bh_raw_reg <= 8'd4;
            ba_raw_reg <= 11'd320;
            bd_raw_reg <= 11'd120;
            rev_reg    <= 1'b0;
            state_reg  <= GEO_READY;
            across_reg <= 11'd320;
            area_reg   <= 14'd8;
            kept_reg   <= 14'd640;
            dstep_reg  <= DSTEP_W'(152);
            cnt_reg    <= 4'd0;
        end
        else
        begin
            sw_raw_reg <= sw_raw_next;
            bw_raw_reg <= bw_raw_next;
            bh_raw_reg <= bh_raw_next;
            ba_raw_reg <= ba_raw_next;
            bd_raw_reg <= bd_raw_next;
            rev_reg    <= rev_next;
            state_reg  <= state_next;
            across_reg <= across_next;
            area_reg   <= area_next;
            kept_reg   <= kept_next;
            dstep_reg  <= dstep_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    always_comb
    begin
        geom.sw      = sw_c;
        geom.bw      = bw_c;
        geom.bh      = bh_c;
        geom.bd      = bd_c;
        geom.across  = across_reg;
        geom.kept    = kept_reg;
        geom.dstep   = dstep_reg;
        geom.reverse = rev_reg;
    end

endmodule

>>> sv/bma_front.sv
// ----------------------------------------------------------------------------
// bma_front: pixel intake and tile accumulation
// Tracks raster position, crops, and sums each tile in a column memory with
// a one-deep write stage; completed tile sums go to the queue.
// ----------------------------------------------------------------------------
module bma_front
    import bma_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  geom_t             geom,
    input  logic              geom_ready,
    input  logic [QCNT_W-1:0] q_count,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    output logic              push,
    output entry_t            push_data
);

    logic [12:0]           col_reg, col_next;
    logic [6:0]            rit_reg, rit_next;
    logic [9:0]            tr_reg, tr_next;
    logic [5:0]            ci_reg, ci_next;
    logic [TILE_IDX_W-1:0] ti_reg, ti_next;
    logic                  done_reg, done_next;

    logic                  s2_valid_reg, s2_valid_next;
    logic [TILE_IDX_W-1:0] s2_addr_reg;
    logic [7:0]            s2_pix_reg;
    logic                  s2_load_reg, s2_last_reg, s2_re_reg, s2_ie_reg;
    logic                  fwd_reg, fwd_next;
    logic [SUM_W-1:0]      fwd_data_reg;
    logic [SUM_W-1:0]      rd_data_reg;
    logic [SUM_W-1:0]      sum_mem [TILES_ACROSS_MAX];

    logic                  accept, work, issue;
    logic                  in_crop, tile_ok, ci_last, rit_last, tr_last, col_wrap;
    logic                  row_end_w, image_end_w;
    logic [SUM_W-1:0]      base, sum_w;

    always_comb
    begin
        in_crop     = {1'b0, col_reg} < geom.kept;
        tile_ok     = {1'b0, ti_reg} < geom.across;
        ci_last     = ({1'b0, ci_reg} + 7'd1) >= geom.bw;
        rit_last    = ({1'b0, rit_reg} + 8'd1) >= geom.bh;
        tr_last     = ({1'b0, tr_reg} + 11'd1) >= geom.bd;
        col_wrap    = ({1'b0, col_reg} + 14'd1) >= geom.sw;
        row_end_w   = ({1'b0, ti_reg} + 11'd1) >= geom.across;
        image_end_w = row_end_w && tr_last;
        push        = s2_valid_reg && s2_last_reg;
        s_tready    = geom_ready && (({1'b0, q_count} + 4'(push)) < 4'(QUEUE_DEPTH));
        accept      = s_tvalid && s_tready;
        work        = accept && !done_reg;
        issue       = work && in_crop && tile_ok;
    end

    always_comb
    begin
        col_next  = col_reg;
        rit_next  = rit_reg;
        tr_next   = tr_reg;
        ci_next   = ci_reg;
        ti_next   = ti_reg;
        done_next = done_reg;
        if (work)
        begin
            if (in_crop)
            begin
                if (ci_last)
                begin
                    ci_next = 6'd0;
                    ti_next = (ti_reg != TILE_IDX_W'(TILES_ACROSS_MAX - 1)) ? ti_reg + 1'b1 : ti_reg;
                end
                else
                begin
                    ci_next = ci_reg + 6'd1;
                end
            end
            if (col_wrap)
            begin
                col_next = 13'd0;
                ci_next  = 6'd0;
                ti_next  = '0;
                if (rit_last)
                begin
                    rit_next = 7'd0;
                    if (tr_last)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        tr_next = tr_reg + 10'd1;
                    end
                end
                else
                begin
                    rit_next = rit_reg + 7'd1;
                end
            end
            else
            begin
                col_next = col_reg + 13'd1;
            end
        end
    end

    always_comb
    begin
        s2_valid_next = issue;
        fwd_next      = issue && s2_valid_reg && (s2_addr_reg == ti_reg);
        base          = fwd_reg ? fwd_data_reg : rd_data_reg;
        sum_w         = s2_load_reg ? {13'd0, s2_pix_reg} : base + {13'd0, s2_pix_reg};
        push_data.sum       = sum_w;
        push_data.tile      = s2_addr_reg;
        push_data.row_end   = s2_re_reg;
        push_data.image_end = s2_ie_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= 13'd0;
            rit_reg      <= 7'd0;
            tr_reg       <= 10'd0;
            ci_reg       <= 6'd0;
            ti_reg       <= '0;
            done_reg     <= 1'b0;
            s2_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            rit_reg      <= rit_next;
            tr_reg       <= tr_next;
            ci_reg       <= ci_next;
            ti_reg       <= ti_next;
            done_reg     <= done_next;
            s2_valid_reg <= s2_valid_next;
            fwd_reg      <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s2_addr_reg  <= ti_reg;
            s2_pix_reg   <= s_tdata;
            s2_load_reg  <= (rit_reg == 7'd0) && (ci_reg == 6'd0);
            s2_last_reg  <= rit_last && ci_last;
            s2_re_reg    <= row_end_w;
            s2_ie_reg    <= image_end_w;
            fwd_data_reg <= sum_w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            sum_mem[s2_addr_reg] <= sum_w;
        end
        if (issue)
        begin
            rd_data_reg <= sum_mem[ti_reg];
        end
    end

endmodule

>>> sv/bma_queue.sv
// ----------------------------------------------------------------------------
// bma_queue: tile queue
// Short first-in first-out store of finished tile sums between the front
// and the back.
// ----------------------------------------------------------------------------
module bma_queue
    import bma_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  entry_t            push_data,
    input  logic              pop,
    output entry_t            pop_data,
    output logic [QCNT_W-1:0] count
);

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
        count       = count_reg;
        pop_data    = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/bma_back.sv
// ----------------------------------------------------------------------------
// bma_back: tile level and glyph output
// Divides a tile sum by 19 times the tile area one quotient bit a cycle,
// saturates at the top level, picks the glyph and holds the output beat.
// ----------------------------------------------------------------------------
module bma_back
    import bma_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  geom_t       geom,
    input  logic        q_valid,
    input  entry_t      q_data,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [6:0] char_code, [16:7] tile_column, rest zero
    output logic        m_tlast,    // row_end
    output logic        m_tuser     // image_end
);

    bk_state_t             state_reg, state_next;
    logic [SUM_W-1:0]      rem_reg;
    logic [3:0]            lvl_reg;
    logic [1:0]            qbit_reg;
    logic [TILE_IDX_W-1:0] tile_reg;
    logic                  re_reg, ie_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [6:0]            out_char_reg;
    logic [TILE_IDX_W-1:0] out_col_reg;
    logic                  out_re_reg, out_ie_reg;

    logic [SUM_W:0]        d22, lim, shifted;
    logic                  sat, ge, emit;

    always_comb
    begin
        d22     = (SUM_W + 1)'(geom.dstep);
        lim     = (d22 << 3) + (d22 << 2) + d22;
        sat     = {1'b0, rem_reg} >= lim;
        shifted = d22 << qbit_reg;
        ge      = {1'b0, rem_reg} >= shifted;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:  state_next = q_valid ? BK_CHECK : BK_IDLE;
            BK_CHECK: state_next = sat ? BK_EMIT : BK_DIV;
            BK_DIV:   state_next = (qbit_reg == 2'd0) ? BK_EMIT : BK_DIV;
            BK_EMIT:  state_next = emit ? BK_IDLE : BK_EMIT;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop  = (state_reg == BK_IDLE) && q_valid;
        emit = (state_reg == BK_EMIT) && (!out_valid_reg || m_tready);
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rem_reg  <= q_data.sum;
            lvl_reg  <= 4'd0;
            qbit_reg <= 2'd3;
            tile_reg <= q_data.tile;
            re_reg   <= q_data.row_end;
            ie_reg   <= q_data.image_end;
        end
        if ((state_reg == BK_CHECK) && sat)
        begin
            lvl_reg <= LEVEL_TOP;
        end
        if (state_reg == BK_DIV)
        begin
            if (ge)
            begin
                rem_reg           <= SUM_W'({1'b0, rem_reg} - shifted);
                lvl_reg[qbit_reg] <= 1'b1;
            end
            qbit_reg <= qbit_reg - 2'd1;
        end
        if (emit)
        begin
            out_char_reg <= ramp_char(lvl_reg, geom.reverse);
            out_col_reg  <= tile_reg;
            out_re_reg   <= re_reg;
            out_ie_reg   <= ie_reg;
        end
    end

    always_comb
    begin
        m_tvalid = out_valid_reg;
        m_tdata  = {7'd0, out_col_reg, out_char_reg};
        m_tlast  = out_re_reg;
        m_tuser  = out_ie_reg;
    end

endmodule

>>> sv/block_mean_ascii_map.sv
// ----------------------------------------------------------------------------
// block_mean_ascii_map: tile mean to ASCII glyph mapper
// Crops a raster grey image, averages each tile and emits one glyph per tile.
// ----------------------------------------------------------------------------
//  channel   dir  width  contents
//  s_*       in   8      pixel_value
//  m_*       out  24+1+1 char_code, tile_column; tlast row_end; tuser image_end
//  cfg_*     in   3+14   register index, write data
//
//  Front takes one pixel a cycle and holds s_tready low while the 4-entry
//  tile queue has no room, during a register write and during the geometry
//  recompute after it. Back runs check, division and emit per tile, skipping
//  division on a saturated tile, so tiles 7 or more pixels wide never stall
//  the input while m_tready is high; narrower ones can fill the queue on a
//  tile's last row. Reset restores register defaults and starts a new frame.
// ----------------------------------------------------------------------------
module block_mean_ascii_map
    import bma_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,    // [7:0] pixel_value
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,    // [6:0] char_code, [16:7] tile_column
    output logic                   m_tlast,    // row_end
    output logic                   m_tuser,    // [0] image_end
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    geom_t             geom;
    logic              geom_ready;
    logic              push, pop;
    entry_t            push_data, pop_data;
    logic [QCNT_W-1:0] q_count;

    bma_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom),
        .ready     (geom_ready)
    );

    bma_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .geom       (geom),
        .geom_ready (geom_ready),
        .q_count    (q_count),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push       (push),
        .push_data  (push_data)
    );

    bma_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .count     (q_count)
    );

    bma_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .geom     (geom),
        .q_valid  (q_count != '0),
        .q_data   (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
